// ===== design/kvr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvr_pkg
// Shared types, codes and constants of the key-hold velocity ramp.
// ----------------------------------------------------------------------------
package kvr_pkg;

  // request types
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // key codes carried by a key event
  localparam int  CODE_W = 4;
  localparam logic [CODE_W-1:0] CODE_UP         = 4'd0;
  localparam logic [CODE_W-1:0] CODE_DOWN       = 4'd1;
  localparam logic [CODE_W-1:0] CODE_LEFT       = 4'd2;
  localparam logic [CODE_W-1:0] CODE_RIGHT      = 4'd3;
  localparam logic [CODE_W-1:0] CODE_BRAKE      = 4'd4;
  localparam logic [CODE_W-1:0] CODE_UP_LEFT    = 4'd5;
  localparam logic [CODE_W-1:0] CODE_UP_RIGHT   = 4'd6;
  localparam logic [CODE_W-1:0] CODE_DOWN_LEFT  = 4'd7;
  localparam logic [CODE_W-1:0] CODE_DOWN_RIGHT = 4'd8;

  // key slots in the stamp table
  localparam int NUM_KEYS = 5;
  localparam int K_UP     = 0;
  localparam int K_DOWN   = 1;
  localparam int K_LEFT   = 2;
  localparam int K_RIGHT  = 3;
  localparam int K_BRAKE  = 4;

  localparam int TIME_W   = 32;
  localparam int HOLD_W   = 16;
  localparam int FACTOR_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WINDOW   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_STEP      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_STEP      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_FRICTION  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_FRICTION  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_BRAKE     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_BRAKE     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 4'd7;

  // register reset values
  localparam logic [HOLD_W-1:0]   RST_HOLD_WINDOW  = 16'd200;
  localparam int                  RST_LIN_STEP     = 2621;
  localparam int                  RST_ANG_STEP     = 1966;
  localparam logic [FACTOR_W-1:0] RST_LIN_FRICTION = 16'd64225;
  localparam logic [FACTOR_W-1:0] RST_ANG_FRICTION = 16'd62259;
  localparam logic [FACTOR_W-1:0] RST_LIN_BRAKE    = 16'd328;
  localparam logic [FACTOR_W-1:0] RST_ANG_BRAKE    = 16'd66;

  // per-axis control from the held-key decode
  typedef struct packed {
    logic brake;
    logic pos;
    logic neg;
  } kvr_axis_ctl_t;

  // keys stamped by one key event
  function automatic logic [NUM_KEYS-1:0] key_mask(input logic [CODE_W-1:0] code);
    logic [NUM_KEYS-1:0] m;
    m = '0;
    unique case (code)
      CODE_UP:         m[K_UP] = 1'b1;
      CODE_DOWN:       m[K_DOWN] = 1'b1;
      CODE_LEFT:       m[K_LEFT] = 1'b1;
      CODE_RIGHT:      m[K_RIGHT] = 1'b1;
      CODE_BRAKE:      m[K_BRAKE] = 1'b1;
      CODE_UP_LEFT:    begin m[K_UP] = 1'b1; m[K_LEFT] = 1'b1; end
      CODE_UP_RIGHT:   begin m[K_UP] = 1'b1; m[K_RIGHT] = 1'b1; end
      CODE_DOWN_LEFT:  begin m[K_DOWN] = 1'b1; m[K_LEFT] = 1'b1; end
      CODE_DOWN_RIGHT: begin m[K_DOWN] = 1'b1; m[K_RIGHT] = 1'b1; end
      default:         m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/key_hold_velocity_ramp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_hold_velocity_ramp_top
// Key-hold velocity ramp: key stamps in, Q1.16 linear/angular commands out.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): req_type, key_code, now_ms. a key event
//   stamps one or two direction keys or the brake key and gives no result; a
//   control tick updates both velocities and gives one result transfer.
//   output channel (out_valid/out_ready): linear_vel, angular_vel, signed Q1.16.
//   config channel (cfg_valid/cfg_ready): cfg_index selects the register,
//   cfg_data carries the value (low bits kept); cfg_ready is always high.
//   write config only while the block is idle.
// pipeline and throughput
//   an item is registered in the input register, the held-key compare and the
//   axis update run while it sits there, and out_valid rises in the cycle after
//   a tick leaves it. one item per cycle is sustained while no tick waits on the
//   output; the velocity registers double as the output register.
// reset
//   rst clears keys-seen flags, both velocities, valid flags, and loads the
//   register defaults. no key counts as held until it is stamped again.
// stall
//   while a result waits, key events keep flowing; a tick waits in the input
//   register and holds in_ready low until the result transfers.
// ----------------------------------------------------------------------------
module key_hold_velocity_ramp_top #(
  parameter int ZERO_THRESHOLD = 66,
  parameter int VEL_FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [kvr_pkg::CODE_W-1:0]        key_code,
  input  logic [kvr_pkg::TIME_W-1:0]        now_ms,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [VEL_FRAC_BITS+1:0]   linear_vel,
  output logic signed [VEL_FRAC_BITS+1:0]   angular_vel,
  // config channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kvr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kvr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int STEP_W = VEL_FRAC_BITS;
  localparam int MAX_W  = VEL_FRAC_BITS + 1;
  // 1.5 in Q1.VEL_FRAC_BITS
  localparam logic [MAX_W-1:0] RST_MAX_SPEED = MAX_W'(3) << (VEL_FRAC_BITS - 1);

  // config registers
  logic [kvr_pkg::HOLD_W-1:0]   hold_window;
  logic [STEP_W-1:0]            lin_step;
  logic [STEP_W-1:0]            ang_step;
  logic [kvr_pkg::FACTOR_W-1:0] lin_friction;
  logic [kvr_pkg::FACTOR_W-1:0] ang_friction;
  logic [kvr_pkg::FACTOR_W-1:0] lin_brake;
  logic [kvr_pkg::FACTOR_W-1:0] ang_brake;
  logic [MAX_W-1:0]             max_speed;

  // input register
  logic                         stage_valid;
  logic                         stage_req;
  logic [kvr_pkg::CODE_W-1:0]   stage_code;
  logic [kvr_pkg::TIME_W-1:0]   stage_time;

  logic                         stage_fire;
  logic                         tick_fire;
  logic [kvr_pkg::NUM_KEYS-1:0] held;
  kvr_pkg::kvr_axis_ctl_t       lin_ctl;
  kvr_pkg::kvr_axis_ctl_t       ang_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_window  <= kvr_pkg::RST_HOLD_WINDOW;
      lin_step     <= STEP_W'(kvr_pkg::RST_LIN_STEP);
      ang_step     <= STEP_W'(kvr_pkg::RST_ANG_STEP);
      lin_friction <= kvr_pkg::RST_LIN_FRICTION;
      ang_friction <= kvr_pkg::RST_ANG_FRICTION;
      lin_brake    <= kvr_pkg::RST_LIN_BRAKE;
      ang_brake    <= kvr_pkg::RST_ANG_BRAKE;
      max_speed    <= RST_MAX_SPEED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kvr_pkg::CFG_HOLD_WINDOW:  hold_window  <= cfg_data[kvr_pkg::HOLD_W-1:0];
        kvr_pkg::CFG_LIN_STEP:     lin_step     <= cfg_data[STEP_W-1:0];
        kvr_pkg::CFG_ANG_STEP:     ang_step     <= cfg_data[STEP_W-1:0];
        kvr_pkg::CFG_LIN_FRICTION: lin_friction <= cfg_data[kvr_pkg::FACTOR_W-1:0];
        kvr_pkg::CFG_ANG_FRICTION: ang_friction <= cfg_data[kvr_pkg::FACTOR_W-1:0];
        kvr_pkg::CFG_LIN_BRAKE:    lin_brake    <= cfg_data[kvr_pkg::FACTOR_W-1:0];
        kvr_pkg::CFG_ANG_BRAKE:    ang_brake    <= cfg_data[kvr_pkg::FACTOR_W-1:0];
        kvr_pkg::CFG_MAX_SPEED:    max_speed    <= cfg_data[MAX_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // key events never need the output side; ticks wait for a free result slot
  assign stage_fire = stage_valid
                      && ((stage_req == kvr_pkg::REQ_KEY) || !out_valid || out_ready);
  assign tick_fire  = stage_fire && (stage_req == kvr_pkg::REQ_TICK);
  assign in_ready   = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_req  <= req_type;
      stage_code <= key_code;
      stage_time <= now_ms;
    end
  end

  // key table; stamps on a key event transfer out of the input register
  kvr_keys u_keys (
    .clk         (clk),
    .rst         (rst),
    .stamp_en    (stage_fire && (stage_req == kvr_pkg::REQ_KEY)),
    .code        (stage_code),
    .now_time    (stage_time),
    .hold_window (hold_window),
    .held        (held)
  );

  // brake overrides both axes; opposite keys cancel to friction decay
  assign lin_ctl = '{brake: held[kvr_pkg::K_BRAKE],
                     pos:   held[kvr_pkg::K_UP],
                     neg:   held[kvr_pkg::K_DOWN]};
  assign ang_ctl = '{brake: held[kvr_pkg::K_BRAKE],
                     pos:   held[kvr_pkg::K_LEFT],
                     neg:   held[kvr_pkg::K_RIGHT]};

  kvr_axis #(
    .VEL_FRAC_BITS  (VEL_FRAC_BITS),
    .ZERO_THRESHOLD (ZERO_THRESHOLD)
  ) u_lin (
    .clk          (clk),
    .rst          (rst),
    .update       (tick_fire),
    .ctl          (lin_ctl),
    .step         (lin_step),
    .friction     (lin_friction),
    .brake_factor (lin_brake),
    .max_speed    (max_speed),
    .vel          (linear_vel)
  );

  kvr_axis #(
    .VEL_FRAC_BITS  (VEL_FRAC_BITS),
    .ZERO_THRESHOLD (ZERO_THRESHOLD)
  ) u_ang (
    .clk          (clk),
    .rst          (rst),
    .update       (tick_fire),
    .ctl          (ang_ctl),
    .step         (ang_step),
    .friction     (ang_friction),
    .brake_factor (ang_brake),
    .max_speed    (max_speed),
    .vel          (angular_vel)
  );

  // velocity registers are the result payload; valid tracks pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a tick that leaves the input register always shows up as a result
  assert property (@(posedge clk) disable iff (rst) tick_fire |=> out_valid)
    else $error("tick transfer did not raise out_valid");

  // velocities only move on a tick
  assert property (@(posedge clk) disable iff (rst)
    !tick_fire |=> ($stable(linear_vel) && $stable(angular_vel)))
    else $error("velocity changed without a tick");

  // a key event in the input register is never held back by the output side
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && (stage_req == kvr_pkg::REQ_KEY)) |-> in_ready)
    else $error("key event stalled");

  // clamp and scale keep the most negative code unreachable
  assert property (@(posedge clk) disable iff (rst)
    (linear_vel != {1'b1, {(VEL_FRAC_BITS+1){1'b0}}})
    && (angular_vel != {1'b1, {(VEL_FRAC_BITS+1){1'b0}}}))
    else $error("velocity out of range");

endmodule

// ===== design/kvr_keys.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvr_keys
// Key stamp table with seen flags and the held-key compare.
// ----------------------------------------------------------------------------
module kvr_keys (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                stamp_en,
  input  logic [kvr_pkg::CODE_W-1:0]          code,
  input  logic [kvr_pkg::TIME_W-1:0]          now_time,
  input  logic [kvr_pkg::HOLD_W-1:0]          hold_window,
  output logic [kvr_pkg::NUM_KEYS-1:0]        held
);

  logic [kvr_pkg::TIME_W-1:0]   stamp [kvr_pkg::NUM_KEYS];
  logic [kvr_pkg::NUM_KEYS-1:0] seen;
  logic [kvr_pkg::NUM_KEYS-1:0] wr_mask;

  assign wr_mask = stamp_en ? kvr_pkg::key_mask(code) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else begin
      seen <= seen | wr_mask;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < kvr_pkg::NUM_KEYS; i++) begin
      if (wr_mask[i]) begin
        stamp[i] <= now_time;
      end
    end
  end

  // age wraps modulo 2^32; held while age is below the window
  always_comb begin
    logic [kvr_pkg::TIME_W-1:0] age;
    for (int i = 0; i < kvr_pkg::NUM_KEYS; i++) begin
      age = now_time - stamp[i];
      held[i] = seen[i] && (age[kvr_pkg::TIME_W-1:kvr_pkg::HOLD_W] == '0)
                && (age[kvr_pkg::HOLD_W-1:0] < hold_window);
    end
  end

endmodule

// ===== design/kvr_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvr_axis
// One velocity axis: state register, scale-and-zero path, accelerate-and-clamp.
// ----------------------------------------------------------------------------
module kvr_axis #(
  parameter int VEL_FRAC_BITS  = 16,
  parameter int ZERO_THRESHOLD = 66
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 update,
  input  kvr_pkg::kvr_axis_ctl_t               ctl,
  input  logic [VEL_FRAC_BITS-1:0]             step,
  input  logic [kvr_pkg::FACTOR_W-1:0]         friction,
  input  logic [kvr_pkg::FACTOR_W-1:0]         brake_factor,
  input  logic [VEL_FRAC_BITS:0]               max_speed,
  output logic signed [VEL_FRAC_BITS+1:0]      vel
);

  localparam int VEL_W  = VEL_FRAC_BITS + 2;
  localparam int STEP_W = VEL_FRAC_BITS;
  localparam int MAX_W  = VEL_FRAC_BITS + 1;
  localparam int ACC_W  = VEL_W + 1;
  localparam int PROD_W = VEL_W + kvr_pkg::FACTOR_W;
  localparam logic [31:0] THR = 32'(ZERO_THRESHOLD);

  logic                         neg;
  logic [VEL_W-1:0]             mag;
  logic [kvr_pkg::FACTOR_W-1:0] factor;
  logic [PROD_W-1:0]            prod;
  logic [VEL_W-1:0]             scaled;
  logic [VEL_W-1:0]             smag;
  logic [VEL_W-1:0]             scale_res;
  logic signed [ACC_W-1:0]      vext;
  logic signed [ACC_W-1:0]      sstep;
  logic signed [ACC_W-1:0]      lim;
  logic signed [ACC_W-1:0]      sum;
  logic signed [ACC_W-1:0]      clamped;
  logic signed [VEL_W-1:0]      vel_next;

  // scale by a Q0.16 factor on the magnitude, truncating toward zero
  assign neg       = vel[VEL_W-1];
  assign mag       = neg ? VEL_W'(~vel + 1'b1) : vel;
  assign factor    = ctl.brake ? brake_factor : friction;
  assign prod      = PROD_W'(mag) * PROD_W'(factor);
  assign scaled    = prod[PROD_W-1:kvr_pkg::FACTOR_W];
  assign smag      = (32'(scaled) < THR) ? '0 : scaled;
  assign scale_res = neg ? VEL_W'(~smag + 1'b1) : smag;

  // accelerate one step and clamp to +/- max speed
  assign vext    = {vel[VEL_W-1], vel};
  assign sstep   = {{(ACC_W-STEP_W){1'b0}}, step};
  assign lim     = {{(ACC_W-MAX_W){1'b0}}, max_speed};
  assign sum     = ctl.pos ? (vext + sstep) : (vext - sstep);

  always_comb begin
    if (sum > lim) begin
      clamped = lim;
    end else if (sum < -lim) begin
      clamped = -lim;
    end else begin
      clamped = sum;
    end
  end

  always_comb begin
    if (!ctl.brake && (ctl.pos ^ ctl.neg)) begin
      vel_next = clamped[VEL_W-1:0];
    end else begin
      vel_next = scale_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel <= '0;
    end else if (update) begin
      vel <= vel_next;
    end
  end

endmodule
